FILE: hw/rtl/bf_interpreter_pin_mapped_assert.svh
// Assertion macros shared by the interpreter RTL.
`ifndef BF_INTERPRETER_PIN_MAPPED_ASSERT_SVH
`define BF_INTERPRETER_PIN_MAPPED_ASSERT_SVH

// same-cycle implication
`define BFI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfi assertion failed");

// next-cycle implication
`define BFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfi assertion failed");

`endif

FILE: hw/rtl/bfi_pkg.sv
`timescale 1ns / 1ps

package bfi_pkg;

  localparam int PROGRAM_DEPTH_DEF = 1024;
  localparam int DATA_CELLS_DEF    = 256;
  localparam int PIN_CELLS         = 12;
  localparam int PIN_TOP           = 13;  // pin driven by pin cell 0

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_START  = 2'd2,
    MODE_STEP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_LEFT  = 3'd0,
    OP_RIGHT = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_SUCCESS   = 3'd1,
    ST_NO_CLOSE  = 3'd2,
    ST_NO_OPEN   = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_IDLE      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_EXEC,
    S_SCAN_ADV,
    S_SCAN_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } sym_dec_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic prog_clear;
    logic append;
    logic run_init;
    logic cell_clear;
    logic fetch;
    logic exec;
    logic scan_adv;
    logic scan_chk;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  running;
    logic  clear_last;
    logic  need_scan;
    logic  scan_end;
    logic  scan_hit;
  } stat_t;

  function automatic sym_dec_t decode_symbol(input logic [7:0] sym);
    sym_dec_t d;
    d.valid = 1'b1;
    d.op    = OP_LEFT;
    unique case (sym)
      CH_LT:    d.op = OP_LEFT;
      CH_GT:    d.op = OP_RIGHT;
      CH_PLUS:  d.op = OP_INC;
      CH_MINUS: d.op = OP_DEC;
      CH_DOT:   d.op = OP_OUT;
      CH_COMMA: d.op = OP_IN;
      CH_LBR:   d.op = OP_OPEN;
      CH_RBR:   d.op = OP_CLOSE;
      default:  d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/bfi_ctrl.sv
`timescale 1ns / 1ps

module bfi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bfi_pkg::stat_t stat,
  output logic          busy,
  output bfi_pkg::cmd_t cmd
);
  import bfi_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_START: state_next = S_CLEAR;
          MODE_STEP:  state_next = stat.running ? S_EXEC : S_DONE;
          default:    state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_DONE;
      end
      S_EXEC: begin
        state_next = stat.need_scan ? S_SCAN_ADV : S_DONE;
      end
      S_SCAN_ADV: begin
        state_next = stat.scan_end ? S_DONE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_next = stat.scan_hit ? S_DONE : S_SCAN_ADV;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.capture = start;
      S_DECODE: begin
        unique case (stat.mode)
          MODE_CLEAR:  cmd.prog_clear = 1'b1;
          MODE_APPEND: cmd.append     = 1'b1;
          MODE_START:  cmd.run_init   = 1'b1;
          MODE_STEP:   cmd.fetch      = stat.running;
          default:     cmd.fetch      = 1'b0;
        endcase
      end
      S_CLEAR:    cmd.cell_clear = 1'b1;
      S_EXEC:     cmd.exec       = 1'b1;
      S_SCAN_ADV: cmd.scan_adv   = 1'b1;
      S_SCAN_CHK: cmd.scan_chk   = 1'b1;
      S_DONE:     cmd.finish     = 1'b1;
      default:    cmd            = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bfi_datapath.sv
`timescale 1ns / 1ps

module bfi_datapath #(
  parameter int PROGRAM_DEPTH = bfi_pkg::PROGRAM_DEPTH_DEF,
  parameter int DATA_CELLS    = bfi_pkg::DATA_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bfi_pkg::cmd_t                      cmd,
  output bfi_pkg::stat_t                     stat,
  input  logic [1:0]                         mode,
  input  logic [7:0]                         symbol,
  input  logic [11:0]                        pin_levels,
  input  logic [7:0]                         serial_byte,
  input  logic                               serial_valid,
  output logic                               done,
  output logic [2:0]                         status,
  output logic                               pin_write_valid,
  output logic [3:0]                         pin_number,
  output logic                               pin_level,
  output logic                               serial_out_valid,
  output logic [7:0]                         serial_out_byte,
  output logic [$clog2(PROGRAM_DEPTH+1)-1:0] program_position
);
  import bfi_pkg::*;

  localparam int PAW   = $clog2(PROGRAM_DEPTH);
  localparam int PLW   = $clog2(PROGRAM_DEPTH + 1);
  localparam int TOTAL = PIN_CELLS + DATA_CELLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int DAW   = $clog2(DATA_CELLS);

  // captured item
  mode_t       mode_q;
  logic [7:0]  sym_q;
  logic [11:0] pins_q;
  logic [7:0]  sbyte_q;
  logic        svalid_q;

  // machine state
  logic [PLW-1:0] len;
  logic [PLW-1:0] ip;
  logic [AW-1:0]  ptr;
  logic           running;
  status_t        held_status;
  logic [PLW-1:0] pos;
  logic [PLW-1:0] depth;
  logic           scan_fwd;
  logic [DAW-1:0] clr_cnt;

  // stores
  logic [2:0]     prog_mem [PROGRAM_DEPTH];
  logic [2:0]     prog_rdata;
  logic [7:0]     cell_mem [DATA_CELLS];
  logic [7:0]     cell_rdata;
  logic [7:0]     pin_cells [PIN_CELLS];

  sym_dec_t       sym_dec;
  op_t            op;
  logic           is_pin;
  logic [3:0]     pidx;
  logic [AW-1:0]  data_off;
  logic [DAW-1:0] data_addr;
  logic [7:0]     cell_val;
  logic [PLW-1:0] ip_inc;
  logic [PLW-1:0] pos_inc;
  logic           can_append;

  logic           ip_upd;
  logic [PLW-1:0] ip_val;
  logic           stop;
  status_t        stop_code;
  logic           ptr_upd;
  logic [AW-1:0]  ptr_val;
  logic           cell_upd;
  logic [7:0]     cell_wval;
  logic           pos_upd;
  logic [PLW-1:0] pos_val;
  logic           depth_upd;
  logic [PLW-1:0] depth_val;
  logic           prog_re;
  logic [PAW-1:0] prog_raddr;
  logic           out_pin;
  logic           out_ser;
  logic           need_scan;
  logic           scan_end;
  logic           scan_hit;
  logic           mem_we;
  logic [DAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;

  assign sym_dec    = decode_symbol(sym_q);
  assign op         = op_t'(prog_rdata);
  assign is_pin     = (ptr < AW'(PIN_CELLS));
  assign pidx       = is_pin ? ptr[3:0] : 4'd0;
  assign data_off   = ptr - AW'(PIN_CELLS);
  assign data_addr  = data_off[DAW-1:0];
  assign cell_val   = is_pin ? pin_cells[pidx] : cell_rdata;
  assign ip_inc     = ip + PLW'(1);
  assign pos_inc    = pos + PLW'(1);
  assign can_append = (len < PLW'(PROGRAM_DEPTH));

  always_comb begin
    ip_upd     = 1'b0;
    ip_val     = ip_inc;
    stop       = 1'b0;
    stop_code  = ST_SUCCESS;
    ptr_upd    = 1'b0;
    ptr_val    = ptr;
    cell_upd   = 1'b0;
    cell_wval  = cell_val;
    pos_upd    = 1'b0;
    pos_val    = pos;
    depth_upd  = 1'b0;
    depth_val  = depth;
    prog_re    = 1'b0;
    prog_raddr = ip[PAW-1:0];
    out_pin    = 1'b0;
    out_ser    = 1'b0;
    need_scan  = 1'b0;
    scan_end   = 1'b0;
    scan_hit   = 1'b0;

    if (cmd.fetch) begin
      prog_re = 1'b1;
    end

    if (cmd.exec) begin
      unique case (op)
        OP_LEFT: begin
          ip_upd  = 1'b1;
          ptr_upd = 1'b1;
          ptr_val = ptr - AW'(1);
          if (ptr == '0) begin
            stop      = 1'b1;
            stop_code = ST_UNDERFLOW;
          end
        end
        OP_RIGHT: begin
          ip_upd  = 1'b1;
          ptr_upd = 1'b1;
          ptr_val = ptr + AW'(1);
          if (ptr == AW'(TOTAL - 1)) begin
            stop      = 1'b1;
            stop_code = ST_OVERFLOW;
          end
        end
        OP_INC: begin
          ip_upd    = 1'b1;
          cell_upd  = 1'b1;
          cell_wval = cell_val + 8'd1;
        end
        OP_DEC: begin
          ip_upd    = 1'b1;
          cell_upd  = 1'b1;
          cell_wval = cell_val - 8'd1;
        end
        OP_OUT: begin
          ip_upd  = 1'b1;
          out_pin = is_pin;
          out_ser = !is_pin;
        end
        OP_IN: begin
          ip_upd   = 1'b1;
          cell_upd = 1'b1;
          if (is_pin) begin
            cell_wval = {7'd0, pins_q[4'(PIN_CELLS - 1) - pidx]};
          end else begin
            cell_wval = svalid_q ? sbyte_q : 8'hFF;
          end
        end
        OP_OPEN, OP_CLOSE: begin
          // jump when '[' sees zero or ']' sees nonzero
          need_scan = (op == OP_OPEN) ? (cell_val == 8'd0) : (cell_val != 8'd0);
          if (need_scan) begin
            pos_upd   = 1'b1;
            pos_val   = ip;
            depth_upd = 1'b1;
            depth_val = PLW'(1);
          end else begin
            ip_upd = 1'b1;
          end
        end
        default: ip_upd = 1'b1;
      endcase
    end

    if (cmd.scan_adv) begin
      if (scan_fwd) begin
        if (pos_inc >= len) begin
          scan_end  = 1'b1;
          ip_upd    = 1'b1;
          ip_val    = len;
          stop      = 1'b1;
          stop_code = ST_NO_CLOSE;
        end else begin
          pos_upd    = 1'b1;
          pos_val    = pos_inc;
          prog_re    = 1'b1;
          prog_raddr = pos_inc[PAW-1:0];
        end
      end else begin
        if (pos == '0) begin
          scan_end  = 1'b1;
          ip_upd    = 1'b1;
          ip_val    = '0;
          stop      = 1'b1;
          stop_code = ST_NO_OPEN;
        end else begin
          pos_upd    = 1'b1;
          pos_val    = pos - PLW'(1);
          prog_re    = 1'b1;
          prog_raddr = pos_val[PAW-1:0];
        end
      end
    end

    if (cmd.scan_chk) begin
      // a bracket of the scan's own kind nests deeper, the other one unwinds
      if ((op == OP_OPEN) || (op == OP_CLOSE)) begin
        depth_upd = 1'b1;
        if ((op == OP_OPEN) == scan_fwd) begin
          depth_val = depth + PLW'(1);
        end else begin
          depth_val = depth - PLW'(1);
        end
      end
      if (depth_upd && (depth_val == '0)) begin
        scan_hit = 1'b1;
        ip_upd   = 1'b1;
        ip_val   = scan_fwd ? pos_inc : pos;
      end
    end

    if (ip_upd && !stop && (ip_val >= len)) begin
      stop      = 1'b1;
      stop_code = ST_SUCCESS;
    end
  end

  always_comb begin
    stat.mode       = mode_q;
    stat.running    = running;
    stat.clear_last = (clr_cnt == DAW'(DATA_CELLS - 1));
    stat.need_scan  = need_scan;
    stat.scan_end   = scan_end;
    stat.scan_hit   = scan_hit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      ip          <= '0;
      ptr         <= AW'(PIN_CELLS);
      running     <= 1'b0;
      held_status <= ST_IDLE;
      depth       <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.prog_clear) begin
        len         <= '0;
        ip          <= '0;
        running     <= 1'b0;
        held_status <= ST_IDLE;
      end
      if (cmd.append && sym_dec.valid && can_append) begin
        len <= len + PLW'(1);
      end
      if (cmd.run_init) begin
        ptr   <= AW'(PIN_CELLS);
        ip    <= '0;
        depth <= '0;
        if (len != '0) begin
          running     <= 1'b1;
          held_status <= ST_RUNNING;
        end else begin
          running     <= 1'b0;
          held_status <= ST_SUCCESS;
        end
      end
      if (ip_upd)    ip    <= ip_val;
      if (ptr_upd)   ptr   <= ptr_val;
      if (depth_upd) depth <= depth_val;
      if (stop) begin
        running     <= 1'b0;
        held_status <= stop_code;
      end
    end
  end

  // captured item, scan position, clear sweep, pin cells, results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q           <= mode_t'(mode);
      sym_q            <= symbol;
      pins_q           <= pin_levels;
      sbyte_q          <= serial_byte;
      svalid_q         <= serial_valid;
      pin_write_valid  <= 1'b0;
      pin_number       <= 4'd0;
      pin_level        <= 1'b0;
      serial_out_valid <= 1'b0;
      serial_out_byte  <= 8'd0;
    end
    if (cmd.exec) begin
      scan_fwd <= (op == OP_OPEN);
    end
    if (pos_upd) pos <= pos_val;
    if (cmd.run_init) begin
      clr_cnt <= '0;
      for (int c = 0; c < PIN_CELLS; c++) begin
        pin_cells[c] <= {7'd0, pins_q[PIN_CELLS - 1 - c]};
      end
    end else if (cmd.cell_clear) begin
      clr_cnt <= clr_cnt + DAW'(1);
    end
    if (cell_upd && is_pin) begin
      pin_cells[pidx] <= cell_wval;
    end
    if (out_pin) begin
      pin_write_valid <= 1'b1;
      pin_number      <= 4'(PIN_TOP) - pidx;
      pin_level       <= (cell_val != 8'd0);
    end
    if (out_ser) begin
      serial_out_valid <= 1'b1;
      serial_out_byte  <= cell_val;
    end
    if (cmd.finish) begin
      status           <= held_status;
      program_position <= ip;
    end
  end

  // program store
  always_ff @(posedge clk) begin
    if (cmd.append && sym_dec.valid && can_append) begin
      prog_mem[len[PAW-1:0]] <= sym_dec.op;
    end
    if (prog_re) begin
      prog_rdata <= prog_mem[prog_raddr];
    end
  end

  // data cell store, one write port shared by the clear sweep and execution
  assign mem_we    = cmd.cell_clear || (cell_upd && !is_pin);
  assign mem_waddr = cmd.cell_clear ? clr_cnt : data_addr;
  assign mem_wdata = cmd.cell_clear ? 8'd0 : cell_wval;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.fetch) begin
      cell_rdata <= cell_mem[data_addr];
    end
  end

endmodule

FILE: hw/rtl/bf_interpreter_pin_mapped.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// item in   start / busy           mode, symbol, pin_levels, serial_byte, serial_valid
// result    done (one cycle)       status, pin_write_valid, pin_number, pin_level,
//                                  serial_out_valid, serial_out_byte, program_position
//
// An item is taken when start is high and busy is low; done pulses once per item.
// Clear, append, and a step while stopped finish after the decode state; a simple step also passes the execute state.
// Start clears the data store one cell per cycle, all DATA_CELLS cells, before done.
// A bracket jump walks the program symbol by symbol, through an advance and a check state, one program store read each.
// rst is synchronous; the program store holds whatever it held and is rewritten by appends.
// The receiver takes done as it comes; nothing stalls the result side.

module bf_interpreter_pin_mapped #(
  parameter int PROGRAM_DEPTH = bfi_pkg::PROGRAM_DEPTH_DEF,
  parameter int DATA_CELLS    = bfi_pkg::DATA_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic [7:0]                         symbol,
  input  logic [11:0]                        pin_levels,
  input  logic [7:0]                         serial_byte,
  input  logic                               serial_valid,
  output logic                               done,
  output logic [2:0]                         status,
  output logic                               pin_write_valid,
  output logic [3:0]                         pin_number,
  output logic                               pin_level,
  output logic                               serial_out_valid,
  output logic [7:0]                         serial_out_byte,
  output logic [$clog2(PROGRAM_DEPTH+1)-1:0] program_position
);
  import bfi_pkg::*;

`include "bf_interpreter_pin_mapped_assert.svh"

  cmd_t  cmd;
  stat_t stat;

  bfi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bfi_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_CELLS    (DATA_CELLS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .mode             (mode),
    .symbol           (symbol),
    .pin_levels       (pin_levels),
    .serial_byte      (serial_byte),
    .serial_valid     (serial_valid),
    .done             (done),
    .status           (status),
    .pin_write_valid  (pin_write_valid),
    .pin_number       (pin_number),
    .pin_level        (pin_level),
    .serial_out_valid (serial_out_valid),
    .serial_out_byte  (serial_out_byte),
    .program_position (program_position)
  );

  `BFI_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `BFI_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `BFI_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `BFI_ASSERT_SAME(a_one_output, clk, rst, done && pin_write_valid, !serial_out_valid)
  `BFI_ASSERT_SAME(a_pin_range, clk, rst, done && pin_write_valid, pin_number >= 4'd2 && pin_number <= 4'd13)

endmodule
